// ===== src/acct_pkg.sv =====
// Shared types and constants for the accelerate-then-cruise travel time block.
package acct_pkg;

  localparam int unsigned WORD_W  = 64;  // dividend / radicand / quotient
  localparam int unsigned DVSR_W  = 17;  // divisor (2*accel needs 17 bits)
  localparam int unsigned REM_W   = 35;  // partial remainder incl. shifted-in bits
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned MUL_A_W = 24;
  localparam int unsigned MUL_B_W = 28;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned TIME_W  = 44;

  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd63;  // 64 quotient bits
  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd31;  // 32 root bits

  // 1e6 = 5^6 * 2^6 and 2e12 = 5^12 * 2^13: odd factor multiplied, power of two shifted
  localparam logic [MUL_B_W-1:0] FIVE_POW6  = 28'd15625;
  localparam logic [MUL_B_W-1:0] FIVE_POW12 = 28'd244140625;

  typedef enum logic [0:0] {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_mode_t;

  typedef struct packed {
    logic     start;
    ds_mode_t mode;
  } ds_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

endpackage

// ===== src/acct_divsqrt.sv =====
// Shared shift-subtract unit: restoring divide (one bit per cycle) or square root.
module acct_divsqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  acct_pkg::ds_cmd_t                  cmd,
  input  logic [acct_pkg::WORD_W-1:0]        operand,
  input  logic [acct_pkg::DVSR_W-1:0]        divisor,
  output acct_pkg::ds_stat_t                 stat,
  output logic [acct_pkg::WORD_W-1:0]        result
);

  logic [acct_pkg::WORD_W-1:0] word;
  logic [acct_pkg::REM_W-1:0]  rem;
  logic [acct_pkg::ROOT_W-1:0] root;
  logic [acct_pkg::DVSR_W-1:0] dvsr;
  acct_pkg::ds_mode_t          mode;
  logic [acct_pkg::CNT_W-1:0]  cnt;
  logic                        busy;
  logic                        done;

  logic [acct_pkg::REM_W-1:0]  rem_sh;
  logic [acct_pkg::REM_W-1:0]  sub_b;
  logic [acct_pkg::REM_W:0]    diff;
  logic                        ge;
  logic [acct_pkg::REM_W-1:0]  rem_next;
  logic [acct_pkg::CNT_W-1:0]  last;

  // one subtractor serves both modes
  always_comb begin
    case (mode)
      acct_pkg::DS_SQRT: begin
        rem_sh = {rem[acct_pkg::REM_W-3:0], word[acct_pkg::WORD_W-1 -: 2]};
        sub_b  = {1'b0, root, 2'b01};
        last   = acct_pkg::SQRT_LAST;
      end
      default: begin
        rem_sh = {rem[acct_pkg::REM_W-2:0], word[acct_pkg::WORD_W-1]};
        sub_b  = {{(acct_pkg::REM_W-acct_pkg::DVSR_W){1'b0}}, dvsr};
        last   = acct_pkg::DIV_LAST;
      end
    endcase
    diff     = {1'b0, rem_sh} - {1'b0, sub_b};
    ge       = ~diff[acct_pkg::REM_W];
    rem_next = ge ? diff[acct_pkg::REM_W-1:0] : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + acct_pkg::CNT_W'(1);
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      word <= operand;
      rem  <= '0;
      root <= '0;
      dvsr <= divisor;
      mode <= cmd.mode;
    end else if (busy) begin
      rem <= rem_next;
      if (mode == acct_pkg::DS_SQRT) begin
        word <= {word[acct_pkg::WORD_W-3:0], 2'b00};
        root <= {root[acct_pkg::ROOT_W-2:0], ge};
      end else begin
        word <= {word[acct_pkg::WORD_W-2:0], ge};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result = (mode == acct_pkg::DS_SQRT)
                  ? {{(acct_pkg::WORD_W-acct_pkg::ROOT_W){1'b0}}, root} : word;

endmodule

// ===== src/accel_cruise_travel_time_unit.sv =====
// Top level: sequencer, shared multiplier and divide/sqrt unit for travel time.
// Cruise branch: three divisions; accelerating-only branch: two divisions plus a
//   square root; an invalid item goes straight to the output register.
// Throughput: one item at a time; a new item is accepted only after the previous
//   result has been loaded into the output register.
// Reset: sequencer to idle, no result pending, divide/sqrt unit idle; datapath registers are not reset.
module accel_cruise_travel_time_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] accel,
  input  logic [16:0] cruise_speed,
  input  logic [23:0] distance,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [43:0] travel_time_us
);

  // One-hot sequencer. Each division is mul -> launch -> wait.
  typedef enum logic [15:0] {
    ST_IDLE      = 16'h0001,
    ST_MUL_VV    = 16'h0002,  // v*v
    ST_DIV_DACC  = 16'h0004,  // v*v / (2a)
    ST_WAIT_DACC = 16'h0008,
    ST_MUL_T1    = 16'h0010,  // v*1e6
    ST_DIV_T1    = 16'h0020,  // / a
    ST_WAIT_T1   = 16'h0040,
    ST_MUL_T2    = 16'h0080,  // (d - d_acc)*1e6
    ST_DIV_T2    = 16'h0100,  // / v
    ST_WAIT_T2   = 16'h0200,
    ST_MUL_X     = 16'h0400,  // 2e12*d
    ST_DIV_X     = 16'h0800,  // / a
    ST_WAIT_X    = 16'h1000,
    ST_SQRT_X    = 16'h2000,  // launch root of the quotient
    ST_WAIT_SQ   = 16'h4000,
    ST_FINISH    = 16'h8000   // hand result to output register
  } state_t;

  state_t state;
  state_t state_next;

  // latched operands (a and v positive, d non-negative, once the validity check passes)
  logic [15:0] a_r;
  logic [15:0] v_r;
  logic [22:0] d_r;
  logic [22:0] diff_r;                     // d - d_acc, cruise branch only
  logic [acct_pkg::PROD_W-1:0] prod;
  logic [acct_pkg::TIME_W-1:0] t_acc;
  logic                        ok_c;

  logic [acct_pkg::MUL_A_W-1:0] mul_a;
  logic [acct_pkg::MUL_B_W-1:0] mul_b;

  acct_pkg::ds_cmd_t               ds_cmd;
  acct_pkg::ds_stat_t              ds_stat;
  logic [acct_pkg::WORD_W-1:0]     ds_operand;
  logic [acct_pkg::DVSR_W-1:0]     ds_divisor;
  logic [acct_pkg::WORD_W-1:0]     ds_result;

  logic in_ok;
  logic in_acc;
  logic out_load;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  // accel > 0, speed > 0, distance >= 0
  assign in_ok = ~accel[16] & (accel[15:0] != 16'd0)
               & ~cruise_speed[16] & (cruise_speed[15:0] != 16'd0)
               & ~distance[23];
  assign out_load = (state == ST_FINISH) & (~out_valid | out_ready);

  acct_divsqrt u_divsqrt (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ds_cmd),
    .operand (ds_operand),
    .divisor (ds_divisor),
    .stat    (ds_stat),
    .result  (ds_result)
  );

  // multiplier operand select
  always_comb begin
    case (state)
      ST_MUL_VV: begin
        mul_a = {8'b0, v_r};
        mul_b = {12'b0, v_r};
      end
      ST_MUL_T1: begin
        mul_a = {8'b0, v_r};
        mul_b = acct_pkg::FIVE_POW6;
      end
      ST_MUL_T2: begin
        mul_a = {1'b0, diff_r};
        mul_b = acct_pkg::FIVE_POW6;
      end
      ST_MUL_X: begin
        mul_a = {1'b0, d_r};
        mul_b = acct_pkg::FIVE_POW12;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide/sqrt launch; powers of two from 1e6 and 2e12 applied as shifts
  always_comb begin
    ds_cmd.start = 1'b0;
    ds_cmd.mode  = acct_pkg::DS_DIV;
    ds_operand   = '0;
    ds_divisor   = {1'b0, a_r};
    case (state)
      ST_DIV_DACC: begin
        ds_cmd.start = 1'b1;
        ds_operand   = {12'b0, prod};
        ds_divisor   = {a_r, 1'b0};
      end
      ST_DIV_T1: begin
        ds_cmd.start = 1'b1;
        ds_operand   = {6'b0, prod, 6'b0};
      end
      ST_DIV_T2: begin
        ds_cmd.start = 1'b1;
        ds_operand   = {6'b0, prod, 6'b0};
        ds_divisor   = {1'b0, v_r};
      end
      ST_DIV_X: begin
        ds_cmd.start = 1'b1;
        ds_operand   = {prod[acct_pkg::PROD_W-2:0], 13'b0};
      end
      ST_SQRT_X: begin
        ds_cmd.start = 1'b1;
        ds_cmd.mode  = acct_pkg::DS_SQRT;
        ds_operand   = ds_result;
      end
      default: begin
        ds_cmd.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_acc) state_next = in_ok ? ST_MUL_VV : ST_FINISH;
      ST_MUL_VV:    state_next = ST_DIV_DACC;
      ST_DIV_DACC:  state_next = ST_WAIT_DACC;
      ST_WAIT_DACC: begin
        if (ds_stat.done) begin
          state_next = ({41'b0, d_r} >= ds_result) ? ST_MUL_T1 : ST_MUL_X;
        end
      end
      ST_MUL_T1:    state_next = ST_DIV_T1;
      ST_DIV_T1:    state_next = ST_WAIT_T1;
      ST_WAIT_T1:   if (ds_stat.done) state_next = ST_MUL_T2;
      ST_MUL_T2:    state_next = ST_DIV_T2;
      ST_DIV_T2:    state_next = ST_WAIT_T2;
      ST_WAIT_T2:   if (ds_stat.done) state_next = ST_FINISH;
      ST_MUL_X:     state_next = ST_DIV_X;
      ST_DIV_X:     state_next = ST_WAIT_X;
      ST_WAIT_X:    if (ds_stat.done) state_next = ST_SQRT_X;
      ST_SQRT_X:    state_next = ST_WAIT_SQ;
      ST_WAIT_SQ:   if (ds_stat.done) state_next = ST_FINISH;
      ST_FINISH:    if (out_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_acc) begin
      a_r   <= accel[15:0];
      v_r   <= cruise_speed[15:0];
      d_r   <= distance[22:0];
      ok_c  <= in_ok;
      t_acc <= '0;
    end
    case (state)
      ST_WAIT_DACC: diff_r <= d_r - ds_result[22:0];
      ST_WAIT_T1:   if (ds_stat.done) t_acc <= ds_result[acct_pkg::TIME_W-1:0];
      ST_WAIT_T2: begin
        if (ds_stat.done) t_acc <= t_acc + ds_result[acct_pkg::TIME_W-1:0];
      end
      ST_WAIT_SQ:   if (ds_stat.done) t_acc <= ds_result[acct_pkg::TIME_W-1:0];
      default: begin
      end
    endcase
    if (out_load) begin
      ok             <= ok_c;
      travel_time_us <= t_acc;
    end
  end

endmodule
